FILE: src/frcl_pkg.sv
// package for the flash ring configuration log
// holds operation and status codes, header constants, transaction types and states
// no dependencies
package frcl_pkg;

  // operation codes
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_WSTART = 3'd1;
  localparam logic [2:0] OP_WBYTE  = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [1:0] ST_NO_RECORD = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  // record header layout
  localparam int unsigned HDR_BYTES  = 12;
  localparam logic [3:0]  HDR_LAST   = 4'd11;
  localparam logic [31:0] LOG_MAGIC  = 32'h4346_4721;
  localparam logic [7:0]  ERASED     = 8'hFF;

  // configuration registers
  localparam logic REG_LIMIT = 1'b0;
  localparam logic [10:0] LIMIT_RESET = 11'd1012;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic [9:0] record_length_in;
    logic [9:0] read_offset;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       committed;
    logic [3:0] write_unit_out;
    logic [3:0] found_unit;
    logic [9:0] found_length;
    logic [7:0] read_data;
  } rsp_item_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_RD,
    S_INIT_CHK,
    S_ERASE,
    S_WSTART,
    S_WBYTE,
    S_HDR_WR,
    S_FH_RD,
    S_FH_CHK,
    S_FEVAL,
    S_FP_RD,
    S_FP_CHK,
    S_FCMP,
    S_RD_RD,
    S_RD_GET,
    S_FINISH
  } state_t;

endpackage

FILE: src/frcl_if.sv
// command and response channel interfaces of the flash ring configuration log
// depends on frcl_pkg for the transaction types
interface frcl_cmd_if import frcl_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface frcl_rsp_if import frcl_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: src/frcl_store.sv
// byte store of the log: single port ram with registered read data
// no package dependencies
module frcl_store #(
  parameter int DEPTH = 16384,
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write and registered read at one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/flash_ring_config_log.sv
// Flash ring configuration log. A command transaction carries one operation
// (init scan, write start, write byte, find latest, read byte); each gives
// exactly one response transaction with status, commit flag, write pointer,
// located record and read byte. Records sit one per unit in a byte ram.
// All work runs through a single byte port of the ram under a sequencer,
// and cmd.ready is high only while the sequencer is idle. Work per command:
//   write byte: one payload byte, plus the 12-byte header when it commits
//   read byte: one payload byte; unknown op: response only
//   write start: a sector erase at a sector start, plus the header
//   for a zero-length commit
//   init scan: bytes examined in turn, plus a sector erase if full
//   find latest: header and payload bytes of each unit visited
// After reset the ram is swept to 0xFF, one byte a cycle; no command is
// taken meanwhile but the register port works.
// A finished response waits in an output register; a command may be accepted
// while it waits, and the next response is held back until it is taken.
// read_buffer_limit lies at byte address 0 of the register port.
module flash_ring_config_log import frcl_pkg::*; #(
  parameter int UNIT_BYTES = 1024,
  parameter int UNITS_IN_SECTOR = 4,
  parameter int SECTOR_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  frcl_cmd_if.sink          cmd,
  frcl_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SECTOR_BYTES = UNIT_BYTES * UNITS_IN_SECTOR;
  localparam int UNIT_TOTAL = UNITS_IN_SECTOR * SECTOR_COUNT;
  localparam int STORE_BYTES = SECTOR_BYTES * SECTOR_COUNT;
  localparam int PAYLOAD_MAX = UNIT_BYTES - HDR_BYTES;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(SECTOR_BYTES);
  localparam int LW = $clog2(UNIT_BYTES);
  localparam int UNW = $clog2(UNIT_TOTAL);
  localparam int SW = $clog2(SECTOR_COUNT);
  localparam int SUBW = (UNITS_IN_SECTOR > 1) ? $clog2(UNITS_IN_SECTOR) : 1;

  state_t state, state_next;

  // ram port
  logic          store_we;
  logic [AW-1:0] addr;
  logic [7:0]    store_wdata;
  logic [7:0]    store_rdata;

  // sweep and scan
  logic [CW-1:0]  cnt;
  logic [SW-1:0]  scan_sec;
  logic           from_init;

  // write pointer and write in progress
  logic [SW-1:0]   next_sec;
  logic [SUBW-1:0] next_sub;
  logic            write_active;
  logic [9:0]      write_total;
  logic [9:0]      write_offset;
  logic [7:0]      running_xor;

  // located record
  logic [UNW-1:0] loc_unit;
  logic [LW-1:0]  loc_len;

  // find cursor
  logic [SW-1:0]   cur_sec;
  logic [SUBW-1:0] cur_sub;
  logic [UNW:0]    it;
  logic [3:0]      hidx;
  logic            magic_ok;
  logic [31:0]     len_word;
  logic [31:0]     chk_word;
  logic [7:0]      xacc;
  logic [LW-1:0]   pc;

  // latched command fields and result
  logic [7:0]  data_byte_r;
  logic [9:0]  rlen_r;
  logic [1:0]  status_r;
  logic        committed_r;
  logic [7:0]  rdata_r;
  logic        out_valid;
  rsp_item_t   out_item;

  logic [10:0] read_buffer_limit;

  logic accept;
  logic out_free;

  function automatic logic [AW-1:0] unit_base(input logic [UNW-1:0] u);
    return AW'(32'(u) * UNIT_BYTES);
  endfunction

  function automatic logic [UNW-1:0] unit_of(input logic [SW-1:0] s, input logic [SUBW-1:0] b);
    return UNW'(32'(s) * UNITS_IN_SECTOR + 32'(b));
  endfunction

  function automatic logic [SW-1:0] sec_wrap_inc(input logic [SW-1:0] s);
    return (32'(s) == SECTOR_COUNT - 1) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SW-1:0] sec_wrap_dec(input logic [SW-1:0] s);
    return (s == '0) ? SW'(SECTOR_COUNT - 1) : s - 1'b1;
  endfunction

  // cursor one unit back from the write pointer and from the find cursor
  logic [SW-1:0]   nd_sec, cd_sec;
  logic [SUBW-1:0] nd_sub, cd_sub;
  always_comb begin
    nd_sec = (next_sub == '0) ? sec_wrap_dec(next_sec) : next_sec;
    nd_sub = (next_sub == '0) ? SUBW'(UNITS_IN_SECTOR - 1) : next_sub - 1'b1;
    cd_sec = (cur_sub == '0) ? sec_wrap_dec(cur_sec) : cur_sec;
    cd_sub = (cur_sub == '0) ? SUBW'(UNITS_IN_SECTOR - 1) : cur_sub - 1'b1;
  end

  logic [UNW-1:0] next_unit;
  logic [UNW-1:0] cur_unit;
  assign next_unit = unit_of(next_sec, next_sub);
  assign cur_unit  = unit_of(cur_sec, cur_sub);

  // header byte for the commit sequence
  logic [31:0] hdr_word;
  logic [7:0]  hdr_byte;
  always_comb begin
    case (hidx[3:2])
      2'd0:    hdr_word = LOG_MAGIC;
      2'd1:    hdr_word = {22'b0, write_total};
      default: hdr_word = {24'b0, running_xor};
    endcase
    hdr_byte = hdr_word[8*hidx[1:0] +: 8];
  end

  // handshakes
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIMIT) ? {21'b0, read_buffer_limit} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_buffer_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT) begin
      read_buffer_limit <= pwdata[10:0];
    end
  end

  frcl_store #(
    .DEPTH(STORE_BYTES),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(store_we),
    .addr(addr),
    .wdata(store_wdata),
    .rdata(store_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram write controls
  always_comb begin
    state_next  = state;
    store_we    = 1'b0;
    store_wdata = ERASED;
    unique case (state)
      S_CLEAR: begin
        store_we = 1'b1;
        if (32'(addr) == STORE_BYTES - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd.data.op)
            OP_INIT:   state_next = S_INIT_RD;
            OP_WSTART: state_next = S_WSTART;
            OP_WBYTE:  state_next = S_WBYTE;
            OP_FIND:   state_next = S_FH_RD;
            OP_READ: begin
              if (32'(cmd.data.read_offset) < 32'(loc_len)) state_next = S_RD_RD;
              else state_next = S_FINISH;
            end
            default:   state_next = S_FINISH;
          endcase
        end
      end
      S_INIT_RD: state_next = S_INIT_CHK;
      S_INIT_CHK: begin
        if (store_rdata != ERASED) begin
          if (32'(scan_sec) == SECTOR_COUNT - 1) state_next = S_ERASE;
          else state_next = S_INIT_RD;
        end else if (32'(cnt) == SECTOR_BYTES - 1) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_INIT_RD;
        end
      end
      S_ERASE: begin
        store_we = 1'b1;
        if (32'(cnt) == SECTOR_BYTES - 1) begin
          if (!from_init && write_total == '0) state_next = S_HDR_WR;
          else state_next = S_FINISH;
        end
      end
      S_WSTART: begin
        if (32'(rlen_r) > PAYLOAD_MAX) state_next = S_FINISH;
        else if (next_sub == '0) state_next = S_ERASE;
        else if (rlen_r == '0) state_next = S_HDR_WR;
        else state_next = S_FINISH;
      end
      S_WBYTE: begin
        if (write_active && write_offset < write_total) begin
          store_we    = 1'b1;
          store_wdata = data_byte_r;
          if (write_offset + 1'b1 == write_total) state_next = S_HDR_WR;
          else state_next = S_FINISH;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_HDR_WR: begin
        store_we    = 1'b1;
        store_wdata = hdr_byte;
        if (hidx == HDR_LAST) state_next = S_FINISH;
      end
      S_FH_RD: state_next = S_FH_CHK;
      S_FH_CHK: begin
        if (hidx == HDR_LAST) state_next = S_FEVAL;
        else state_next = S_FH_RD;
      end
      S_FEVAL: begin
        if (magic_ok && len_word != '0 && len_word <= 32'(PAYLOAD_MAX)) begin
          state_next = S_FP_RD;
        end else if (32'(it) == UNIT_TOTAL) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_FH_RD;
        end
      end
      S_FP_RD: state_next = S_FP_CHK;
      S_FP_CHK: begin
        if (32'(pc) + 1 == len_word) state_next = S_FCMP;
        else state_next = S_FP_RD;
      end
      S_FCMP: begin
        if ({24'b0, xacc} == chk_word || 32'(it) == UNIT_TOTAL) state_next = S_FINISH;
        else state_next = S_FH_RD;
      end
      S_RD_RD:  state_next = S_RD_GET;
      S_RD_GET: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // control registers: write pointer, write in progress, located record, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      next_sec     <= '0;
      next_sub     <= '0;
      write_active <= 1'b0;
      write_total  <= '0;
      write_offset <= '0;
      running_xor  <= '0;
      loc_unit     <= '0;
      loc_len      <= '0;
      out_valid    <= 1'b0;
    end else begin
      // response register: loaded on finish, emptied when taken
      if (state == S_FINISH && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && cmd.data.op == OP_INIT) write_active <= 1'b0;
        end
        S_INIT_CHK: begin
          if (store_rdata != ERASED) begin
            if (32'(scan_sec) == SECTOR_COUNT - 1) begin
              next_sec <= '0;
              next_sub <= '0;
            end
          end else if (32'(cnt) == SECTOR_BYTES - 1) begin
            next_sec <= scan_sec;
            next_sub <= '0;
          end
        end
        S_WSTART: begin
          if (32'(rlen_r) <= PAYLOAD_MAX) begin
            write_active <= 1'b1;
            write_total  <= rlen_r;
            write_offset <= '0;
            running_xor  <= '0;
          end
        end
        S_WBYTE: begin
          if (write_active && write_offset < write_total) begin
            running_xor  <= running_xor ^ data_byte_r;
            write_offset <= write_offset + 1'b1;
          end
        end
        S_HDR_WR: begin
          if (hidx == HDR_LAST) begin
            write_active <= 1'b0;
            if (32'(next_sub) == UNITS_IN_SECTOR - 1) begin
              next_sub <= '0;
              next_sec <= sec_wrap_inc(next_sec);
            end else begin
              next_sub <= next_sub + 1'b1;
            end
          end
        end
        S_FEVAL: begin
          if (!(magic_ok && len_word != '0 && len_word <= 32'(PAYLOAD_MAX)) &&
              32'(it) == UNIT_TOTAL) begin
            loc_unit <= '0;
            loc_len  <= '0;
          end
        end
        S_FCMP: begin
          if ({24'b0, xacc} == chk_word) begin
            if (len_word > 32'(read_buffer_limit)) begin
              loc_unit <= '0;
              loc_len  <= '0;
            end else begin
              loc_unit <= cur_unit;
              loc_len  <= LW'(len_word);
            end
          end else if (32'(it) == UNIT_TOTAL) begin
            loc_unit <= '0;
            loc_len  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else begin
      case (state)
        S_CLEAR: addr <= addr + 1'b1;
        S_IDLE: begin
          if (accept) begin
            data_byte_r <= cmd.data.data_byte;
            rlen_r      <= cmd.data.record_length_in;
            status_r    <= ST_OK;
            committed_r <= 1'b0;
            rdata_r     <= '0;
            case (cmd.data.op)
              OP_INIT: begin
                addr     <= '0;
                cnt      <= '0;
                scan_sec <= '0;
              end
              OP_WBYTE: addr <= unit_base(next_unit) + AW'(HDR_BYTES) + AW'(write_offset);
              OP_FIND: begin
                cur_sec  <= nd_sec;
                cur_sub  <= nd_sub;
                it       <= (UNW+1)'(1);
                hidx     <= '0;
                magic_ok <= 1'b1;
                addr     <= unit_base(unit_of(nd_sec, nd_sub));
              end
              OP_READ: begin
                addr <= unit_base(loc_unit) + AW'(HDR_BYTES) + AW'(cmd.data.read_offset);
              end
              default: ;
            endcase
          end
        end
        S_INIT_CHK: begin
          if (store_rdata != ERASED) begin
            cnt <= '0;
            if (32'(scan_sec) == SECTOR_COUNT - 1) begin
              addr      <= '0;
              from_init <= 1'b1;
            end else begin
              scan_sec <= scan_sec + 1'b1;
              addr     <= AW'((32'(scan_sec) + 1) * SECTOR_BYTES);
            end
          end else begin
            addr <= addr + 1'b1;
            cnt  <= cnt + 1'b1;
          end
        end
        S_WSTART: begin
          from_init <= 1'b0;
          cnt       <= '0;
          hidx      <= '0;
          if (next_sub == '0) addr <= AW'(32'(sec_wrap_inc(next_sec)) * SECTOR_BYTES);
          else addr <= unit_base(next_unit);
          if (32'(rlen_r) > PAYLOAD_MAX) status_r <= ST_TOO_LONG;
          else if (next_sub != '0 && rlen_r == '0) committed_r <= 1'b1;
        end
        S_ERASE: begin
          cnt <= cnt + 1'b1;
          if (32'(cnt) == SECTOR_BYTES - 1 && !from_init) begin
            addr <= unit_base(next_unit);
            hidx <= '0;
            if (write_total == '0) committed_r <= 1'b1;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_WBYTE: begin
          hidx <= '0;
          addr <= unit_base(next_unit);
          if (write_active && write_offset + 1'b1 == write_total) committed_r <= 1'b1;
        end
        S_HDR_WR: begin
          hidx <= hidx + 1'b1;
          addr <= addr + 1'b1;
        end
        S_FH_CHK: begin
          if (hidx[3:2] == 2'd0) begin
            if (store_rdata != LOG_MAGIC[8*hidx[1:0] +: 8]) magic_ok <= 1'b0;
          end else if (hidx[3:2] == 2'd1) begin
            len_word[8*hidx[1:0] +: 8] <= store_rdata;
          end else begin
            chk_word[8*hidx[1:0] +: 8] <= store_rdata;
          end
          hidx <= hidx + 1'b1;
          addr <= addr + 1'b1;
        end
        S_FEVAL: begin
          xacc <= '0;
          pc   <= '0;
          if (magic_ok && len_word != '0 && len_word <= 32'(PAYLOAD_MAX)) begin
            addr <= unit_base(cur_unit) + AW'(HDR_BYTES);
          end else if (32'(it) == UNIT_TOTAL) begin
            status_r <= ST_NO_RECORD;
          end else begin
            it       <= it + 1'b1;
            cur_sec  <= cd_sec;
            cur_sub  <= cd_sub;
            hidx     <= '0;
            magic_ok <= 1'b1;
            addr     <= unit_base(unit_of(cd_sec, cd_sub));
          end
        end
        S_FP_CHK: begin
          xacc <= xacc ^ store_rdata;
          pc   <= pc + 1'b1;
          addr <= addr + 1'b1;
        end
        S_FCMP: begin
          if ({24'b0, xacc} == chk_word) begin
            if (len_word > 32'(read_buffer_limit)) status_r <= ST_TOO_LARGE;
          end else if (32'(it) == UNIT_TOTAL) begin
            status_r <= ST_NO_RECORD;
          end else begin
            it       <= it + 1'b1;
            cur_sec  <= cd_sec;
            cur_sub  <= cd_sub;
            hidx     <= '0;
            magic_ok <= 1'b1;
            addr     <= unit_base(unit_of(cd_sec, cd_sub));
          end
        end
        S_RD_GET: rdata_r <= store_rdata;
        S_FINISH: begin
          if (out_free) begin
            out_item.status         <= status_r;
            out_item.committed      <= committed_r;
            out_item.write_unit_out <= 4'(next_unit);
            out_item.found_unit     <= 4'(loc_unit);
            out_item.found_length   <= 10'(loc_len);
            out_item.read_data      <= rdata_r;
          end
        end
        default: ;
      endcase
    end
  end

  // a commit always reports success
  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.committed |-> rsp.data.status == ST_OK)
    else $error("commit reported with a failing status");

  // the sequencer leaves idle on every accepted command
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("command port still ready after a transaction");

  // an open write never has all its bytes while idle
  a_write_open: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && write_active |-> write_offset < write_total)
    else $error("finished write left uncommitted");

  // located length always fits a unit
  a_loc_len: assert property (@(posedge clk) disable iff (rst)
    32'(loc_len) <= PAYLOAD_MAX)
    else $error("located record length beyond unit payload");

endmodule

FILE: dv/frcl_checker.sv
`timescale 1ns / 100ps
// checker for the flash ring configuration log: watches both channels and the register port
// keeps its own image of the byte store and compares every response; depends on frcl_pkg and frcl_if
module frcl_checker import frcl_pkg::*; #(
  parameter int UNIT_BYTES = 1024,
  parameter int UNITS_IN_SECTOR = 4,
  parameter int SECTOR_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  frcl_cmd_if         cmd,
  frcl_rsp_if         rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fails,
  output int          pending
);

  localparam int SECTOR_SPAN = UNIT_BYTES * UNITS_IN_SECTOR;
  localparam int UNIT_COUNT  = UNITS_IN_SECTOR * SECTOR_COUNT;
  localparam int STORE_SIZE  = SECTOR_SPAN * SECTOR_COUNT;
  localparam int PAYLOAD_MAX = UNIT_BYTES - HDR_BYTES;
  localparam logic [2:0] LIMIT_ADDR = {REG_LIMIT, 2'b00};

  // mirror of the byte store and the log pointers
  logic [7:0]  store_img [STORE_SIZE];
  int unsigned wr_unit, wr_total, wr_off, loc_unit, loc_len;
  logic        wr_busy;
  logic [7:0]  run_xor;
  logic [10:0] limit;
  rsp_item_t   expected_rsps[$];

  function automatic logic [31:0] word_at(int unsigned a);
    return {store_img[a+3], store_img[a+2], store_img[a+1], store_img[a]};
  endfunction

  function automatic void put_word(int unsigned a, logic [31:0] v);
    for (int i = 0; i < 4; i++) store_img[a+i] = v[8*i +: 8];
  endfunction

  function automatic void wipe_sector(int unsigned s);
    int unsigned base;
    base = (s % SECTOR_COUNT) * SECTOR_SPAN;
    for (int i = 0; i < SECTOR_SPAN; i++) store_img[base+i] = ERASED;
  endfunction

  function automatic bit sector_clear(int unsigned s);
    for (int i = 0; i < SECTOR_SPAN; i++)
      if (store_img[s*SECTOR_SPAN+i] != ERASED) return 1'b0;
    return 1'b1;
  endfunction

  // payload length of a valid record in unit u, zero when invalid
  function automatic int unsigned record_len(int unsigned u);
    int unsigned base, len;
    logic [31:0] x;
    base = u * UNIT_BYTES;
    x = '0;
    if (word_at(base) != LOG_MAGIC) return 0;
    len = word_at(base + 4);
    if (len == 0 || len > PAYLOAD_MAX) return 0;
    for (int unsigned i = 0; i < len; i++) x ^= {24'b0, store_img[base+HDR_BYTES+i]};
    return (x == word_at(base + 8)) ? len : 0;
  endfunction

  function automatic void commit_header();
    int unsigned base;
    base = wr_unit * UNIT_BYTES;
    put_word(base, LOG_MAGIC);
    put_word(base + 4, wr_total);
    put_word(base + 8, {24'b0, run_xor});
    wr_unit = (wr_unit + 1) % UNIT_COUNT;
    wr_busy = 1'b0;
  endfunction

  // apply one command transaction to the mirror and build its response
  function automatic rsp_item_t apply_cmd(cmd_item_t c);
    rsp_item_t r;
    int unsigned s, u, len;
    r = '0;
    u = 0;
    len = 0;
    case (c.op)
      OP_INIT: begin
        wr_busy = 1'b0;
        for (s = 0; s < SECTOR_COUNT; s++) if (sector_clear(s)) break;
        if (s < SECTOR_COUNT) wr_unit = s * UNITS_IN_SECTOR;
        else begin
          wipe_sector(0);
          wr_unit = 0;
        end
      end
      OP_WSTART: begin
        if (c.record_length_in > PAYLOAD_MAX) r.status = ST_TOO_LONG;
        else begin
          if (wr_unit % UNITS_IN_SECTOR == 0) wipe_sector(wr_unit / UNITS_IN_SECTOR + 1);
          wr_busy = 1'b1;
          wr_total = 32'(c.record_length_in);
          wr_off = 0;
          run_xor = '0;
          if (wr_total == 0) begin
            commit_header();
            r.committed = 1'b1;
          end
        end
      end
      OP_WBYTE: begin
        if (wr_busy && wr_off < wr_total) begin
          store_img[wr_unit*UNIT_BYTES + HDR_BYTES + wr_off] = c.data_byte;
          run_xor ^= c.data_byte;
          wr_off++;
          if (wr_off == wr_total) begin
            commit_header();
            r.committed = 1'b1;
          end
        end
      end
      OP_FIND: begin
        for (int unsigned i = 1; i <= UNIT_COUNT; i++) begin
          u = (wr_unit + UNIT_COUNT - i) % UNIT_COUNT;
          len = record_len(u);
          if (len != 0) break;
        end
        if (len == 0 || len > limit) begin
          r.status = (len == 0) ? ST_NO_RECORD : ST_TOO_LARGE;
          loc_unit = 0;
          loc_len = 0;
        end else begin
          loc_unit = u;
          loc_len = len;
        end
      end
      OP_READ: begin
        if (c.read_offset < loc_len && loc_len <= PAYLOAD_MAX)
          r.read_data = store_img[loc_unit*UNIT_BYTES + HDR_BYTES + c.read_offset];
      end
      default: ;
    endcase
    r.write_unit_out = wr_unit[3:0];
    r.found_unit = loc_unit[3:0];
    r.found_length = loc_len[9:0];
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fails++;
    end
  endfunction

  // track configuration, predict on each command, compare on each response
  always @(posedge clk) begin
    rsp_item_t e;
    if (rst) begin
      for (int i = 0; i < STORE_SIZE; i++) store_img[i] = ERASED;
      wr_unit = 0; wr_total = 0; wr_off = 0; wr_busy = 1'b0; run_xor = '0;
      loc_unit = 0; loc_len = 0; limit = LIMIT_RESET;
      fails = 0;
      expected_rsps.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) limit = pwdata[10:0];
      if (cmd.valid && cmd.ready) expected_rsps.push_back(apply_cmd(cmd.data));
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response transaction with no command waiting");
          fails++;
        end else begin
          e = expected_rsps.pop_front();
          compare_field("status", 32'(e.status), 32'(rsp.data.status));
          compare_field("committed", 32'(e.committed), 32'(rsp.data.committed));
          compare_field("write_unit_out", 32'(e.write_unit_out),
                        32'(rsp.data.write_unit_out));
          compare_field("found_unit", 32'(e.found_unit), 32'(rsp.data.found_unit));
          compare_field("found_length", 32'(e.found_length), 32'(rsp.data.found_length));
          compare_field("read_data", 32'(e.read_data), 32'(rsp.data.read_data));
        end
      end
    end
    pending = expected_rsps.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// testbench top for the flash ring configuration log: clock, reset, stimulus and verdict
// depends on frcl_pkg, frcl_if, the block and frcl_checker
module tb;
  import frcl_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fails, pending;
  int          burst_left = 0, sent = 0, ready_hold = 0;

  frcl_cmd_if cmd_ch();
  frcl_rsp_if rsp_ch();

  flash_ring_config_log u_dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  frcl_checker u_chk (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
  );

  always #6 clk = ~clk;

  // receiver: ready runs and stalls of random length
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      if ($urandom_range(0, 1)) begin
        rsp_ch.ready = 1'b1;
        ready_hold = $urandom_range(1, 40);
      end else begin
        rsp_ch.ready = 1'b0;
        ready_hold = $urandom_range(1, 6);
      end
    end else ready_hold--;
  end

  // one command transaction, sent in bursts with random gaps between
  task automatic send_cmd(logic [2:0] op, logic [7:0] db, logic [9:0] len, logic [9:0] off);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    cmd_ch.data = '{op: op, data_byte: db, record_length_in: len, read_offset: off};
    cmd_ch.valid = 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent++;
  endtask

  // register write once the block has answered everything
  task automatic set_read_limit(logic [10:0] v);
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = {REG_LIMIT, 2'b00}; pwdata = {21'b0, v};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // a well-formed record, sometimes abandoned, often followed by find and reads
  task automatic write_record();
    int len, n;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
    send_cmd(OP_WSTART, 8'($urandom), 10'(len), 10'($urandom));
    for (int i = 0; i < n; i++) send_cmd(OP_WBYTE, 8'($urandom), 10'($urandom), 10'($urandom));
    if ($urandom_range(0, 9) < 4) begin
      send_cmd(OP_FIND, 8'($urandom), 10'($urandom), 10'($urandom));
      repeat ($urandom_range(1, 3))
        send_cmd(OP_READ, 8'($urandom), 10'($urandom),
                 10'($urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
                                                : $urandom_range(0, len)));
    end
  endtask

  task automatic random_noise();
    logic [2:0] op;
    op = 3'($urandom_range(0, 7));
    if (op == OP_INIT && $urandom_range(0, 3) != 0) op = OP_WBYTE;
    if (op == OP_WSTART && $urandom_range(0, 1)) begin
      send_cmd(op, 8'($urandom), 10'($urandom_range(1013, 1023)), 10'($urandom));
    end else begin
      send_cmd(op, 8'($urandom), 10'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    logic [10:0] limits [4];
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty log, zero length and too long writes, boundary bytes and offsets
    send_cmd(OP_INIT, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_FIND, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_READ, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_WSTART, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_FIND, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_WSTART, 8'h00, 10'd1013, 10'd0);
    send_cmd(OP_WSTART, 8'hFF, 10'd1023, 10'd1023);
    send_cmd(OP_WBYTE, 8'hFF, 10'd0, 10'd0);
    send_cmd(OP_WSTART, 8'h00, 10'd3, 10'd0);
    send_cmd(OP_WBYTE, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_WBYTE, 8'hFF, 10'd0, 10'd0);
    send_cmd(OP_WBYTE, 8'hA5, 10'd0, 10'd0);
    send_cmd(OP_FIND, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_READ, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_READ, 8'h00, 10'd0, 10'd2);
    send_cmd(OP_READ, 8'h00, 10'd0, 10'd3);
    send_cmd(OP_READ, 8'h00, 10'd0, 10'd1023);
    send_cmd(3'd5, 8'hFF, 10'd1023, 10'd1023);
    send_cmd(3'd7, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_WSTART, 8'h00, 10'd1012, 10'd0);
    send_cmd(OP_WBYTE, 8'h5A, 10'd0, 10'd0);
    send_cmd(OP_INIT, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_FIND, 8'h00, 10'd0, 10'd0);
    send_cmd(OP_READ, 8'h00, 10'd0, 10'd1011);

    // random phases, each under its own read limit
    limits[0] = 11'd0;
    limits[1] = 11'd1024;
    limits[2] = 11'($urandom_range(1, 30));
    limits[3] = LIMIT_RESET;
    for (int p = 0; p < 4; p++) begin
      set_read_limit(limits[p]);
      while (sent < 24 + (p + 1) * 130) begin
        if ($urandom_range(0, 9) < 7) write_record();
        else random_noise();
      end
    end

    @(negedge clk);
    cmd_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (64) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, well beyond the slowest correct run
  initial begin
    #(12.0 * 4000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
